/* rtl/core/esa_pkg.sv */
// shared types and constants of the emergency source aggregator
package esa_pkg;

	localparam int ACT_W         = 2;
	localparam int NODE_W        = 3;
	localparam int SRC_W         = 8;
	localparam int OUT_CNT_W     = 4;
	localparam int BITS_PER_BYTE = 8;

	localparam logic [ACT_W-1:0] ACT_RAISE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SOLVE = 2'd1;

	typedef struct packed {
		logic                 error;
		logic                 node_active;
		logic                 any_active;
		logic                 safety_line;
		logic [OUT_CNT_W-1:0] active_node_count;
	} result_t;

endpackage

/* rtl/core/esa_ram.sv */
// generic single-port-write, registered-read ram
module esa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/esa_update.sv */
// modify step: applies raise or solve to one node word and the global count
module esa_update #(
	parameter int NODES = 8,
	parameter int SOURCE_BYTES = 8,
	localparam int BW = SOURCE_BYTES * esa_pkg::BITS_PER_BYTE,
	localparam int CW = $clog2(BW + 1),
	localparam int GW = $clog2(NODES + 1)
) (
	input  logic [esa_pkg::ACT_W-1:0] action,
	input  logic                      node_ok,
	input  logic [esa_pkg::SRC_W-1:0] source_id,
	input  logic [CW+BW-1:0]          word,
	input  logic [GW-1:0]             g,
	output logic [CW+BW-1:0]          word_nxt,
	output logic                      wr,
	output logic [GW-1:0]             g_nxt,
	output esa_pkg::result_t          res
);
	import esa_pkg::*;

	localparam int SBW = $clog2(BW);

	logic [BW-1:0]  bm;
	logic [CW-1:0]  cnt;
	logic [CW-1:0]  cnt_nxt;
	logic [BW-1:0]  onehot;
	logic [SBW-1:0] bidx;
	logic           src_ok;
	logic           is_mod;
	logic           bit_set;
	logic           do_set;
	logic           do_clr;
	logic           node_act;

	always_comb begin
		bm      = word[BW-1:0];
		cnt     = word[BW +: CW];
		bidx    = SBW'(source_id);
		onehot  = {{(BW-1){1'b0}}, 1'b1} << bidx;
		src_ok  = 32'(source_id) < BW;
		is_mod  = (action == ACT_RAISE) || (action == ACT_SOLVE);
		bit_set = src_ok && ((bm & onehot) != '0);
		do_set  = node_ok && src_ok && (action == ACT_RAISE) && !bit_set;
		do_clr  = node_ok && src_ok && (action == ACT_SOLVE) && bit_set;

		cnt_nxt  = cnt;
		word_nxt = word;
		g_nxt    = g;
		if (do_set) begin
			cnt_nxt  = cnt + CW'(1);
			word_nxt = {cnt_nxt, bm | onehot};
			// idle to active
			if (cnt == '0) begin
				g_nxt = g + GW'(1);
			end
		end else if (do_clr) begin
			cnt_nxt  = cnt - CW'(1);
			word_nxt = {cnt_nxt, bm & ~onehot};
			// active to idle
			if (cnt == CW'(1) && g != '0) begin
				g_nxt = g - GW'(1);
			end
		end
		wr       = do_set || do_clr;
		node_act = node_ok && (cnt_nxt != '0);

		res.error             = node_ok && is_mod && !src_ok;
		res.node_active       = node_act;
		res.any_active        = node_act || (g_nxt != '0);
		res.safety_line       = (g_nxt == '0);
		res.active_node_count = OUT_CNT_W'(g_nxt);
	end

endmodule

/* rtl/core/emergency_source_aggregator.sv */
// top level of the emergency source aggregator
// usage:
//   input channel (in_valid/in_ready) carries action, node_index, source_id;
//   action 0 raises a source, 1 solves it, anything else queries the node.
//   output channel (out_valid/out_ready) returns one result per transaction:
//   error, node_active, any_active, safety_line and active_node_count,
//   all reflecting the state after the update.
// timing:
//   each node's bitmap and source count live in one ram word read at accept;
//   the word comes back from the registered ram read, is modified and
//   written back in the same cycle the result is loaded. in_ready is low
//   while an item waits in the modify stage, so no new transaction is taken
//   before it fires; out_valid is set when the modify stage fires.
// stall: the result register holds while out_ready is low; a further item
//   may be accepted meanwhile and waits in the modify stage.
// reset: arst_n clears the global count, per-node valid bits and handshake
//   state; a node never written since reset reads as all clear.
module emergency_source_aggregator #(
	parameter int NODES = 8,
	parameter int SOURCE_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [esa_pkg::ACT_W-1:0]     action,
	input  logic [esa_pkg::NODE_W-1:0]    node_index,
	input  logic [esa_pkg::SRC_W-1:0]     source_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          error,
	output logic                          node_active,
	output logic                          any_active,
	output logic                          safety_line,
	output logic [esa_pkg::OUT_CNT_W-1:0] active_node_count
);
	import esa_pkg::*;

	localparam int BW = SOURCE_BYTES * BITS_PER_BYTE;
	localparam int CW = $clog2(BW + 1);
	localparam int GW = $clog2(NODES + 1);
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

	logic                  busy_s1;
	logic [ACT_W-1:0]      action_s1;
	logic [NODE_W-1:0]     node_s1;
	logic [SRC_W-1:0]      src_s1;
	logic                  out_valid_q;
	result_t               res_q;
	logic [GW-1:0]         g_q;
	logic [NODES-1:0]      vld_q;

	logic                  in_fire;
	logic                  fire_s1;
	logic                  node_ok;
	logic [AW-1:0]         addr_s1;
	logic [CW+BW-1:0]      rdata;
	logic [CW+BW-1:0]      word;
	logic [CW+BW-1:0]      word_nxt;
	logic                  wr;
	logic [GW-1:0]         g_nxt;
	result_t               res;

	assign in_ready = !busy_s1;
	assign in_fire  = in_valid && in_ready;
	assign fire_s1  = busy_s1 && (!out_valid_q || out_ready);
	assign node_ok  = 32'(node_s1) < NODES;
	assign addr_s1  = AW'(node_s1);
	// untouched entries read as empty
	assign word     = (node_ok && vld_q[addr_s1]) ? rdata : '0;

	esa_ram #(
		.WIDTH(CW + BW),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (fire_s1 && wr),
		.waddr(addr_s1),
		.wdata(word_nxt),
		.re   (in_fire),
		.raddr(AW'(node_index)),
		.rdata(rdata)
	);

	esa_update #(
		.NODES       (NODES),
		.SOURCE_BYTES(SOURCE_BYTES)
	) u_update (
		.action   (action_s1),
		.node_ok  (node_ok),
		.source_id(src_s1),
		.word     (word),
		.g        (g_q),
		.word_nxt (word_nxt),
		.wr       (wr),
		.g_nxt    (g_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			g_q         <= '0;
			vld_q       <= '0;
		end else begin
			if (in_fire) begin
				busy_s1 <= 1'b1;
			end else if (fire_s1) begin
				busy_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
				g_q         <= g_nxt;
				if (wr) begin
					vld_q[addr_s1] <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= action;
			node_s1   <= node_index;
			src_s1    <= source_id;
		end
		if (fire_s1) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign error             = res_q.error;
	assign node_active       = res_q.node_active;
	assign any_active        = res_q.any_active;
	assign safety_line       = res_q.safety_line;
	assign active_node_count = res_q.active_node_count;

`ifndef ASSERT_OFF
	a_g_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(g_q) <= NODES)
		else $error("global node count above node total");

	a_g_vs_vld: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) >= 32'(g_q))
		else $error("active node never written");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_s1 && !in_ready)
		else $error("accepted transaction not held in modify stage");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 && !fire_s1 |=> busy_s1 && $stable(action_s1) && $stable(node_s1))
		else $error("stalled modify stage lost its transaction");
`endif

endmodule
